// ===== hdl/ffa_pkg.sv =====
package ffa_pkg;

  localparam int ARENA_UNITS  = 4096;
  localparam int UNIT_BYTES   = 16;
  localparam int HEADER_UNITS = 2;

  localparam int UNIT_W     = $clog2(ARENA_UNITS);
  localparam int LINK_W     = UNIT_W + 1;
  localparam int UNIT_SHIFT = $clog2(UNIT_BYTES);
  localparam int SIZE_W     = 24;
  localparam int ADDR_W     = 16;
  localparam int FREE_W     = 17;
  localparam int NEED_W     = SIZE_W - UNIT_SHIFT + 1;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef logic [UNIT_W-1:0] unit_t;
  typedef logic [LINK_W-1:0] link_t;

  localparam link_t NULL_LINK = link_t'(ARENA_UNITS);
  localparam logic [FREE_W-1:0] HDR_BYTES = FREE_W'(HEADER_UNITS * UNIT_BYTES);
  localparam logic [FREE_W-1:0] INIT_FREE =
    FREE_W'((ARENA_UNITS - HEADER_UNITS) * UNIT_BYTES);

  typedef struct packed {
    unit_t units;
    logic  busy;
    logic  hdr;
    link_t next;
  } entry_t;

  localparam entry_t INIT_ENTRY  = '{units: unit_t'(ARENA_UNITS - HEADER_UNITS),
                                     busy: 1'b0, hdr: 1'b1, next: NULL_LINK};
  localparam entry_t EMPTY_ENTRY = '{units: '0, busy: 1'b0, hdr: 1'b0,
                                     next: NULL_LINK};

  typedef struct packed {
    logic   main_we;
    unit_t  main_wa;
    entry_t main_wd;
    unit_t  main_ra;
    logic   prev_we;
    unit_t  prev_wa;
    link_t  prev_wd;
    unit_t  prev_ra;
  } store_req_t;

  function automatic logic is_null(link_t l);
    return l[LINK_W-1];
  endfunction

  function automatic logic [ADDR_W-1:0] payload_addr(unit_t b);
    logic [LINK_W+UNIT_SHIFT-1:0] t;
    t = (LINK_W+UNIT_SHIFT)'(b) + (LINK_W+UNIT_SHIFT)'(HEADER_UNITS);
    t = t << UNIT_SHIFT;
    return ADDR_W'(t);
  endfunction

  function automatic logic [FREE_W-1:0] unit_bytes(unit_t n);
    return FREE_W'(n) << UNIT_SHIFT;
  endfunction

endpackage

// ===== hdl/ffa_if.sv =====
interface ffa_req_if import ffa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [SIZE_W-1:0] size_bytes;
  logic [ADDR_W-1:0] address;

  modport source(output valid, cmd, size_bytes, address, input ready);
  modport sink(input valid, cmd, size_bytes, address, output ready);
endinterface

interface ffa_rsp_if import ffa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              ok;
  logic [ADDR_W-1:0] block_address;
  logic [ADDR_W-1:0] avail_bytes;

  modport source(output valid, ok, block_address, avail_bytes, input ready);
  modport sink(input valid, ok, block_address, avail_bytes, output ready);
endinterface

// ===== hdl/ffa_store.sv =====
module ffa_store import ffa_pkg::*; (
  input  logic       clk,
  input  store_req_t ctl,
  output entry_t     main_rd,
  output link_t      prev_rd
);

  entry_t main_mem [ARENA_UNITS];
  link_t  prev_mem [ARENA_UNITS];

  always_ff @(posedge clk) begin
    if (ctl.main_we) begin
      main_mem[ctl.main_wa] <= ctl.main_wd;
    end
    main_rd <= main_mem[ctl.main_ra];
  end

  always_ff @(posedge clk) begin
    if (ctl.prev_we) begin
      prev_mem[ctl.prev_wa] <= ctl.prev_wd;
    end
    prev_rd <= prev_mem[ctl.prev_ra];
  end

endmodule

// ===== hdl/first_fit_heap_allocator_top.sv =====
// Allocate: the chain is walked one block per cycle to the first free block that fits, and
// a split writes the remainder's header in ST_SPLIT2. Free: check, read neighbours, write;
// ST_FREE_WRP merges a free previous block; a block not in use ends after the check.
// A bad address or a zero size goes straight to the result. One request is in work at a
// time; the next is taken in the cycle after the result is registered. Reset is synchronous;
// a clearing pass then sweeps the block memory, and no request is taken until it ends.
module first_fit_heap_allocator_top import ffa_pkg::*; (
  input logic      clk,
  input logic      rst,
  ffa_req_if.sink  req,
  ffa_rsp_if.source rsp
);

  typedef enum logic [8:0] {
    ST_CLEAR    = 9'b000000001,
    ST_IDLE     = 9'b000000010,
    ST_WALK     = 9'b000000100,
    ST_SPLIT2   = 9'b000001000,
    ST_FREE_CHK = 9'b000010000,
    ST_FREE_NX  = 9'b000100000,
    ST_FREE_PV  = 9'b001000000,
    ST_FREE_WRP = 9'b010000000,
    ST_RESP     = 9'b100000000
  } state_t;

  state_t state, state_next;

  unit_t             clr_idx;
  unit_t             cur;
  logic [NEED_W-1:0] need;
  unit_t             split_at;
  link_t             split_next;
  unit_t             split_units;
  unit_t             eb_units;
  link_t             eb_next;
  link_t             pv;
  unit_t             ub;
  link_t             nb;
  logic              mn;
  unit_t             pv_units;
  logic              res_ok;
  logic [ADDR_W-1:0] res_addr;
  logic [FREE_W-1:0] free_total;
  logic              out_valid;
  logic              out_ok;
  logic [ADDR_W-1:0] out_addr;
  logic [ADDR_W-1:0] out_free;

  store_req_t sreq;
  entry_t     e;
  link_t      p_rd;

  ffa_store u_store (
    .clk     (clk),
    .ctl     (sreq),
    .main_rd (e),
    .prev_rd (p_rd)
  );

  logic              free_bad;
  unit_t             free_unit;
  logic [NEED_W-1:0] need_in;
  logic              fit;
  unit_t             rem;
  link_t             s_link;
  logic              do_split;
  logic              blk_ok;
  logic              mn_now;
  unit_t             ub_now;
  link_t             nb_now;
  logic              mp_now;
  logic              out_free_slot;

  assign free_bad = (req.address[UNIT_SHIFT-1:0] != '0) ||
                    (req.address[ADDR_W-1:UNIT_SHIFT] < unit_t'(HEADER_UNITS));
  assign free_unit = unit_t'(req.address[ADDR_W-1:UNIT_SHIFT] - unit_t'(HEADER_UNITS));
  assign need_in = NEED_W'(req.size_bytes[SIZE_W-1:UNIT_SHIFT]) +
                   NEED_W'(|req.size_bytes[UNIT_SHIFT-1:0]);

  assign fit      = !e.busy && (NEED_W'(e.units) >= need);
  assign rem      = e.units - need[UNIT_W-1:0];
  assign s_link   = LINK_W'(cur) + LINK_W'(HEADER_UNITS) + LINK_W'(need[UNIT_W-1:0]);
  assign do_split = (rem > unit_t'(HEADER_UNITS + 1)) && !s_link[UNIT_W];

  assign blk_ok = e.hdr && e.busy;
  assign mn_now = !is_null(eb_next) && !e.busy;
  assign ub_now = mn_now ? (eb_units + unit_t'(HEADER_UNITS) + e.units) : eb_units;
  assign nb_now = mn_now ? e.next : eb_next;
  assign mp_now = !is_null(pv) && !e.busy;

  assign out_free_slot = !out_valid || rsp.ready;

  assign req.ready         = (state == ST_IDLE);
  assign rsp.valid         = out_valid;
  assign rsp.ok            = out_ok;
  assign rsp.block_address = out_addr;
  assign rsp.avail_bytes   = out_free;

  always_comb begin
    sreq         = '0;
    sreq.main_ra = cur;
    sreq.prev_ra = cur;
    state_next   = state;
    unique case (state)
      ST_CLEAR: begin
        sreq.main_we = 1'b1;
        sreq.main_wa = clr_idx;
        sreq.main_wd = (clr_idx == '0) ? INIT_ENTRY : EMPTY_ENTRY;
        sreq.prev_we = 1'b1;
        sreq.prev_wa = clr_idx;
        sreq.prev_wd = NULL_LINK;
        if (clr_idx == '1) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        sreq.main_ra = (req.cmd == CMD_FREE) ? free_unit : '0;
        if (req.valid) begin
          if (req.cmd == CMD_FREE) begin
            state_next = free_bad ? ST_RESP : ST_FREE_CHK;
          end else begin
            state_next = (req.size_bytes == '0) ? ST_RESP : ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (fit) begin
          sreq.main_we = 1'b1;
          sreq.main_wa = cur;
          if (do_split) begin
            sreq.main_wd = '{units: need[UNIT_W-1:0], busy: 1'b1, hdr: 1'b1,
                             next: s_link};
            sreq.prev_we = 1'b1;
            sreq.prev_wa = s_link[UNIT_W-1:0];
            sreq.prev_wd = link_t'(cur);
            state_next   = ST_SPLIT2;
          end else begin
            sreq.main_wd = '{units: e.units, busy: 1'b1, hdr: 1'b1, next: e.next};
            state_next   = ST_RESP;
          end
        end else if (is_null(e.next)) begin
          state_next = ST_RESP;
        end else begin
          sreq.main_ra = e.next[UNIT_W-1:0];
        end
      end
      ST_SPLIT2: begin
        sreq.main_we = 1'b1;
        sreq.main_wa = split_at;
        sreq.main_wd = '{units: split_units, busy: 1'b0, hdr: 1'b1, next: split_next};
        sreq.prev_we = !is_null(split_next);
        sreq.prev_wa = split_next[UNIT_W-1:0];
        sreq.prev_wd = link_t'(split_at);
        state_next   = ST_RESP;
      end
      ST_FREE_CHK: begin
        sreq.main_ra = e.next[UNIT_W-1:0];
        state_next   = blk_ok ? ST_FREE_NX : ST_RESP;
      end
      ST_FREE_NX: begin
        sreq.main_ra = p_rd[UNIT_W-1:0];
        state_next   = ST_FREE_PV;
      end
      ST_FREE_PV: begin
        sreq.main_we = 1'b1;
        sreq.main_wa = cur;
        sreq.main_wd = '{units: ub, busy: 1'b0, hdr: 1'b1, next: nb};
        sreq.prev_we = (mn || mp_now) && !is_null(nb);
        sreq.prev_wa = nb[UNIT_W-1:0];
        sreq.prev_wd = mp_now ? pv : link_t'(cur);
        state_next   = mp_now ? ST_FREE_WRP : ST_RESP;
      end
      ST_FREE_WRP: begin
        sreq.main_we = 1'b1;
        sreq.main_wa = pv[UNIT_W-1:0];
        sreq.main_wd = '{units: pv_units, busy: 1'b0, hdr: 1'b1, next: nb};
        state_next   = ST_RESP;
      end
      ST_RESP: begin
        if (out_free_slot) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_idx    <= '0;
      out_valid  <= 1'b0;
      free_total <= INIT_FREE;
    end else begin
      state <= state_next;
      if ((state == ST_RESP) && out_free_slot) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + unit_t'(1);
        end
        ST_IDLE: begin
          if (req.valid) begin
            cur      <= (req.cmd == CMD_FREE) ? free_unit : '0;
            need     <= need_in;
            res_ok   <= 1'b0;
            res_addr <= '0;
          end
        end
        ST_WALK: begin
          if (fit) begin
            res_ok   <= 1'b1;
            res_addr <= payload_addr(cur);
            if (do_split) begin
              free_total  <= free_total - (unit_bytes(need[UNIT_W-1:0]) + HDR_BYTES);
              split_at    <= s_link[UNIT_W-1:0];
              split_next  <= e.next;
              split_units <= rem - unit_t'(HEADER_UNITS);
            end else begin
              free_total <= free_total - unit_bytes(e.units);
            end
          end else if (!is_null(e.next)) begin
            cur <= e.next[UNIT_W-1:0];
          end
        end
        ST_FREE_CHK: begin
          if (blk_ok) begin
            eb_units   <= e.units;
            eb_next    <= e.next;
            free_total <= free_total + unit_bytes(e.units);
          end
        end
        ST_FREE_NX: begin
          mn <= mn_now;
          ub <= ub_now;
          nb <= nb_now;
          pv <= p_rd;
          if (mn_now) begin
            free_total <= free_total + HDR_BYTES;
          end
        end
        ST_FREE_PV: begin
          res_ok <= 1'b1;
          if (mp_now) begin
            pv_units   <= e.units + unit_t'(HEADER_UNITS) + ub;
            free_total <= free_total + HDR_BYTES;
          end
        end
        ST_RESP: begin
          if (out_free_slot) begin
            out_ok    <= res_ok;
            out_addr  <= res_addr;
            out_free  <= free_total[ADDR_W-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
